@@ sv/bba_pkg.sv @@
// ============================================================================
// bba_pkg
// Shared types and sizing constants of the bitmap block allocator.
// ============================================================================
package bba_pkg;

    // Disk size in blocks and the width of one bitmap word (a power of two).
    localparam int NUM_BLOCKS = 1024;
    localparam int WORD_BITS  = 32;

    // Width of a block number as it travels on the ports.
    localparam int BLK_W  = 10;
    localparam int FIELD_SPAN = 1 << BLK_W;

    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IDX_W     = ADDR_W + BIT_W;
    localparam int CMP_W     = ((IDX_W > BLK_W) ? IDX_W : BLK_W) + 1;

    // Allocation can only hand out blocks that the output field can name.
    localparam int LIMIT       = (NUM_BLOCKS < FIELD_SPAN) ? NUM_BLOCKS : FIELD_SPAN;
    localparam int LIMIT_WORDS = (LIMIT + WORD_BITS - 1) / WORD_BITS;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [BLK_W-1:0] block_number;
    } t_req;

    typedef struct packed {
        logic [BLK_W-1:0] granted_block;
        logic             success;
    } t_resp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE_RD,
        S_FREE_WR,
        S_SCAN,
        S_OUT
    } t_state;

endpackage

@@ sv/bitmap_block_allocator_top.sv @@
// ============================================================================
// bitmap_block_allocator_top
// First-fit allocator of disk blocks over a bitmap held in a word memory.
// ============================================================================
// Usage:
//   Requests arrive on i_in_valid / o_in_stall with an allocate or free
//   command; each request yields exactly one response on o_out_valid /
//   i_out_stall. The first block that allocation may hand out is written on
//   the configuration channel (i_cfg_valid / o_cfg_ready) while idle.
//   A free of a block on the disk reads its word, clears the bit and writes
//   the word back before the output register is loaded. An allocation reads
//   one bitmap word per cycle through the single memory read port, from the
//   word of the search start up to a hit or the last word. One request is
//   in flight at a time; o_in_stall is high until its response is loaded.
//   Reset clears all used bits at once through per-word valid flags and
//   sets the search start to block 0; no clearing pass is needed.
//   While the receiver stalls, the response waits in the output register
//   and the sequencer holds the finished result until that register frees.
// ============================================================================
module bitmap_block_allocator_top
    import bba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [BLK_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_req             i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_resp            o_out_data
);

    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(LIMIT_WORDS - 1);
    localparam logic [CMP_W-1:0]  LIMIT_C   = CMP_W'(LIMIT);
    localparam logic [CMP_W-1:0]  NBLK_C    = CMP_W'(NUM_BLOCKS);

    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_row_vld;
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_rd_vld;

    t_state               r_state, n_state;
    logic [BLK_W-1:0]     r_first;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic [BIT_W-1:0]     r_bit, n_bit;
    logic                 r_issue, n_issue;
    logic                 r_chk_valid;
    logic [ADDR_W-1:0]    r_chk_addr;
    logic [BLK_W-1:0]     r_res_blk, n_res_blk;
    logic                 r_res_ok, n_res_ok;
    logic                 r_out_valid;
    t_resp                r_out_data;

    logic                 in_xfer;
    logic                 rd_en;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 load_out;
    logic                 out_free;

    logic [WORD_BITS-1:0] cur_word;
    logic [WORD_BITS-1:0] masked;
    logic [WORD_BITS-1:0] zeros;
    logic [WORD_BITS-1:0] lowest;
    logic [BIT_W-1:0]     hit_bit;
    logic                 hit;
    logic [CMP_W-1:0]     first_ext;
    logic [CMP_W-1:0]     blk_ext;
    logic [CMP_W-1:0]     hit_idx;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign first_ext = CMP_W'(r_first);
    assign blk_ext   = CMP_W'(i_in_data.block_number);
    assign cur_word  = r_rd_vld ? r_rdata : '0;

    // Blocks below the search start or past the last nameable block count as used.
    always_comb begin
        logic [CMP_W-1:0] idx;
        masked = cur_word;
        for (int i = 0; i < WORD_BITS; i++) begin
            idx = CMP_W'({r_chk_addr, BIT_W'(i)});
            if (idx < first_ext || idx >= LIMIT_C) begin
                masked[i] = 1'b1;
            end
        end
    end

    assign zeros  = ~masked;
    assign lowest = zeros & (~zeros + WORD_BITS'(1));
    assign hit    = r_chk_valid && (zeros != '0);

    always_comb begin
        hit_bit = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (lowest[i]) begin
                hit_bit = hit_bit | BIT_W'(i);
            end
        end
    end

    assign hit_idx = CMP_W'({r_chk_addr, hit_bit});

    // Next state and sequencer registers.
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_bit     = r_bit;
        n_issue   = r_issue;
        n_res_blk = r_res_blk;
        n_res_ok  = r_res_ok;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_res_blk = '0;
                    n_res_ok  = 1'b0;
                    if (i_in_data.mode == MODE_FREE) begin
                        n_addr = ADDR_W'(blk_ext >> BIT_W);
                        n_bit  = i_in_data.block_number[BIT_W-1:0];
                        if (blk_ext < NBLK_C) begin
                            n_res_ok = 1'b1;
                            n_state  = S_FREE_RD;
                        end else begin
                            n_state = S_OUT;
                        end
                    end else begin
                        n_addr  = ADDR_W'(first_ext >> BIT_W);
                        n_issue = 1'b1;
                        if (first_ext < LIMIT_C) begin
                            n_state = S_SCAN;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                end
            end
            S_FREE_RD: begin
                n_state = S_FREE_WR;
            end
            S_FREE_WR: begin
                n_state = S_OUT;
            end
            S_SCAN: begin
                if (r_issue) begin
                    if (r_addr == LAST_WORD) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + ADDR_W'(1);
                    end
                end
                if (hit) begin
                    n_res_blk = hit_idx[BLK_W-1:0];
                    n_res_ok  = 1'b1;
                    n_state   = S_OUT;
                end else if (r_chk_valid && r_chk_addr == LAST_WORD) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory and output controls.
    always_comb begin
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = r_addr;
        wr_data  = cur_word;
        load_out = 1'b0;
        case (r_state)
            S_FREE_RD: begin
                rd_en = 1'b1;
            end
            S_FREE_WR: begin
                wr_en   = 1'b1;
                wr_data = cur_word & ~(WORD_BITS'(1) << r_bit);
            end
            S_SCAN: begin
                rd_en   = r_issue;
                wr_en   = hit;
                wr_addr = r_chk_addr;
                wr_data = cur_word | lowest;
            end
            S_OUT: begin
                load_out = out_free;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[r_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rd_vld <= r_row_vld[r_addr];
            end
            if (wr_en) begin
                r_row_vld[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= '0;
            r_issue     <= 1'b0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_issue <= n_issue;
            if (i_cfg_valid && o_cfg_ready) begin
                r_first <= i_cfg_data;
            end
            // The word read this cycle is checked in the next one.
            r_chk_valid <= (r_state == S_SCAN) && r_issue && !hit;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_bit      <= n_bit;
        r_res_blk  <= n_res_blk;
        r_res_ok   <= n_res_ok;
        r_chk_addr <= r_addr;
        if (load_out) begin
            r_out_data.granted_block <= r_res_blk;
            r_out_data.success       <= r_res_ok;
        end
    end

endmodule

@@ bench/bitmap_block_allocator_top_test.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top_test
// Self-checking bench for the first-fit bitmap block allocator. A table of
// directed requests and register writes runs first, then random phases with
// different search starts mix allocations with frees. Every response is
// checked against an in-bench used-block model or the table row's expected value.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bitmap_block_allocator_top_test;
    import bba_pkg::*;

    localparam int RAND_PHASES     = 10;
    localparam int PHASE_ITEMS     = 125;
    localparam int SETTLE_CYCLES   = 40;
    localparam int LONG_HOLD       = 300;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int DIR_ROWS        = 24;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_REQ,
        ROW_REQ_KNOWN
    } t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic             mode;
        logic [BLK_W-1:0] blk;
        logic [BLK_W-1:0] exp_blk;
        logic             exp_ok;
    } t_dir_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [BLK_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_stall;
    t_req             i_in_data;
    logic             o_out_valid;
    logic             i_out_stall;
    t_resp            o_out_data;

    // Model of the block: one used bit per block plus the search start.
    logic [NUM_BLOCKS-1:0] block_used;
    int                    search_start;

    t_resp            pending_resps[$];
    logic [BLK_W-1:0] granted_blocks[$];
    t_dir_row         dir_rows[DIR_ROWS];

    logic  known_use;
    t_resp known_resp;
    int    mismatch_count;
    int    idle_cycles;
    bit    tx_calm;
    bit    rx_calm;
    bit    long_hold_req;
    int    alloc_pct;

    bitmap_block_allocator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Applies one request to the map and returns the response it should give.
    function automatic t_resp allocate_or_free(t_req r);
        t_resp resp;
        int    b;
        resp = '0;
        if (r.mode == MODE_ALLOC) begin
            for (b = search_start; b < LIMIT; b++) begin
                if (!block_used[b]) begin
                    block_used[b]      = 1'b1;
                    resp.granted_block = BLK_W'(b);
                    resp.success       = 1'b1;
                    break;
                end
            end
        end else if (int'(r.block_number) < NUM_BLOCKS) begin
            block_used[r.block_number] = 1'b0;
            resp.success               = 1'b1;
        end
        return resp;
    endfunction

    always @(posedge i_clk) begin : check_port
        t_resp want;
        t_resp got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                search_start = int'(i_cfg_data);
            if (i_in_valid && !o_in_stall) begin
                want = allocate_or_free(i_in_data);
                if (want.success && i_in_data.mode == MODE_ALLOC)
                    granted_blocks.push_back(want.granted_block);
                if (known_use)
                    want = known_resp;
                pending_resps.push_back(want);
            end
            if (o_out_valid && !i_out_stall) begin
                got = o_out_data;
                if (pending_resps.size() == 0) begin
                    $error("response transfer with no request outstanding");
                    mismatch_count++;
                end else begin
                    want = pending_resps.pop_front();
                    if (got.granted_block !== want.granted_block) begin
                        $error("granted_block: expected %0d, got %0d",
                               want.granted_block, got.granted_block);
                        mismatch_count++;
                    end
                    if (got.success !== want.success) begin
                        $error("success: expected %0d, got %0d",
                               want.success, got.success);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("bitmap_block_allocator_top_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Response side: a random hold before each transfer, and one long hold on request.
    initial begin : drain_side
        int hold;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold          = LONG_HOLD;
            end else begin
                hold = rx_calm ? 0 : $urandom_range(0, 11);
            end
            repeat (hold) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    function automatic int tx_gap();
        return tx_calm ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic idle_tx(input int gap);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // Called just after a falling edge; returns at the edge that takes the transfer.
    task automatic issue(input t_req r, input logic use_known, input t_resp resp);
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        known_use  <= use_known;
        known_resp <= resp;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_empty();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_resps.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_start(input logic [BLK_W-1:0] value);
        wait_empty();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Picks an allocation or a free; frees are mostly of blocks handed out earlier, the rest anywhere on the disk.
    function automatic t_req pick_request();
        t_req r;
        int   idx;
        r.mode         = ($urandom_range(0, 99) < alloc_pct) ? MODE_ALLOC : MODE_FREE;
        r.block_number = BLK_W'($urandom);
        if (r.mode == MODE_FREE) begin
            if (granted_blocks.size() != 0 && $urandom_range(0, 3) != 0) begin
                idx            = $urandom_range(0, granted_blocks.size() - 1);
                r.block_number = granted_blocks[idx];
                granted_blocks.delete(idx);
            end else if ($urandom_range(0, 4) == 0) begin
                r.block_number = $urandom_range(0, 1) ? '1 : '0;
            end
        end
        return r;
    endfunction

    initial begin : stimulus
        t_req  r;
        t_resp resp;
        int    start;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_stall    = 1'b0;
        known_use      = 1'b0;
        known_resp     = '0;
        block_used     = '0;
        search_start   = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        tx_calm        = 1'b0;
        rx_calm        = 1'b0;
        long_hold_req  = 1'b0;
        alloc_pct      = 60;

        dir_rows = '{
            '{ROW_REQ_KNOWN, MODE_ALLOC, 10'd0,    10'd0,    1'b1},
            '{ROW_REQ_KNOWN, MODE_ALLOC, 10'd0,    10'd1,    1'b1},
            '{ROW_REQ_KNOWN, MODE_ALLOC, 10'd0,    10'd2,    1'b1},
            '{ROW_REQ_KNOWN, MODE_FREE,  10'd1,    10'd0,    1'b1},
            '{ROW_REQ_KNOWN, MODE_ALLOC, 10'd0,    10'd1,    1'b1},
            '{ROW_REQ_KNOWN, MODE_FREE,  10'd1023, 10'd0,    1'b1},
            '{ROW_REQ_KNOWN, MODE_FREE,  10'd0,    10'd0,    1'b1},
            '{ROW_REQ_KNOWN, MODE_ALLOC, 10'd1023, 10'd0,    1'b1},
            '{ROW_CFG,       MODE_ALLOC, 10'd1023, 10'd0,    1'b0},
            '{ROW_REQ_KNOWN, MODE_ALLOC, 10'd0,    10'd1023, 1'b1},
            '{ROW_REQ_KNOWN, MODE_ALLOC, 10'd0,    10'd0,    1'b0},
            '{ROW_REQ_KNOWN, MODE_FREE,  10'd2,    10'd0,    1'b1},
            '{ROW_REQ_KNOWN, MODE_ALLOC, 10'd0,    10'd0,    1'b0},
            '{ROW_REQ_KNOWN, MODE_FREE,  10'd1023, 10'd0,    1'b1},
            '{ROW_REQ_KNOWN, MODE_ALLOC, 10'd1023, 10'd1023, 1'b1},
            '{ROW_CFG,       MODE_ALLOC, 10'd31,   10'd0,    1'b0},
            '{ROW_REQ_KNOWN, MODE_ALLOC, 10'd0,    10'd31,   1'b1},
            '{ROW_REQ_KNOWN, MODE_ALLOC, 10'd0,    10'd32,   1'b1},
            '{ROW_CFG,       MODE_ALLOC, 10'd0,    10'd0,    1'b0},
            '{ROW_REQ,       MODE_ALLOC, 10'd0,    10'd0,    1'b0},
            '{ROW_REQ,       MODE_ALLOC, 10'd682,  10'd0,    1'b0},
            '{ROW_REQ,       MODE_FREE,  10'd682,  10'd0,    1'b0},
            '{ROW_REQ,       MODE_FREE,  10'd341,  10'd0,    1'b0},
            '{ROW_REQ,       MODE_FREE,  10'd31,   10'd0,    1'b0}
        };

        // The clock starts high; reset is held low across the rising edges of this window.
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                write_start(dir_rows[i].blk);
            end else begin
                idle_tx(tx_gap());
                @(negedge i_clk);
                r.mode             = dir_rows[i].mode;
                r.block_number     = dir_rows[i].blk;
                resp.granted_block = dir_rows[i].exp_blk;
                resp.success       = dir_rows[i].exp_ok;
                issue(r, dir_rows[i].kind == ROW_REQ_KNOWN, resp);
            end
        end

        // Each phase sets a new search start; the map carries over between phases.
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase % 5)
                0:       start = 0;
                1:       start = NUM_BLOCKS - 1;
                2:       start = NUM_BLOCKS - $urandom_range(1, 64);
                3:       start = $urandom_range(0, NUM_BLOCKS - 1);
                default: start = WORD_BITS * $urandom_range(0, MAP_WORDS - 1);
            endcase
            write_start(BLK_W'(start));
            alloc_pct = $urandom_range(40, 80);
            tx_calm   = ($urandom_range(0, 3) == 0);
            rx_calm   = ($urandom_range(0, 3) == 0);
            if (phase == 5) begin
                // Flood requests while the response side holds off.
                tx_calm       = 1'b1;
                long_hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                idle_tx(tx_gap());
                @(negedge i_clk);
                r = pick_request();
                issue(r, 1'b0, '0);
            end
        end

        wait_empty();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("bitmap_block_allocator_top_test: clean");
        end else begin
            $display("bitmap_block_allocator_top_test: errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/bba_pkg.sv
sv/bitmap_block_allocator_top.sv
bench/bitmap_block_allocator_top_test.sv
